// File: design/prtu_pkg.sv
// Shared types and constants for the particle ring update block.
// Used by prtu_update and particle_ring_update; no dependencies.
package prtu_pkg;

  localparam int POS_W = 24;
  localparam int VEL_W = 16;
  localparam int RAD_W = 16;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] DECAY_RESET  = 16'd62259;
  localparam logic [CFG_W-1:0] GROWTH_RESET = 16'd26;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_DECAY  = 1'b0;
  localparam logic REG_GROWTH = 1'b1;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [VEL_W-1:0] vel_y;
    logic [VEL_W-1:0] vel_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] decay;
    logic [CFG_W-1:0] growth;
  } cfg_t;

endpackage

// File: design/prtu_update.sv
// Per-particle update: saturating move, velocity decay, saturating growth.
// Depends on prtu_pkg.
module prtu_update (
  input  prtu_pkg::entry_t cur,
  input  prtu_pkg::cfg_t   cfg,
  output prtu_pkg::entry_t upd
);

  logic signed [prtu_pkg::POS_W:0]         sum_x, sum_y;
  logic signed [prtu_pkg::VEL_W+prtu_pkg::CFG_W:0] prod_x, prod_y;
  logic        [prtu_pkg::RAD_W:0]         sum_r;

  always_comb begin
    sum_x = {cur.pos_x[prtu_pkg::POS_W-1], cur.pos_x}
          + {{(prtu_pkg::POS_W-prtu_pkg::VEL_W+1){cur.vel_x[prtu_pkg::VEL_W-1]}}, cur.vel_x};
    sum_y = {cur.pos_y[prtu_pkg::POS_W-1], cur.pos_y}
          + {{(prtu_pkg::POS_W-prtu_pkg::VEL_W+1){cur.vel_y[prtu_pkg::VEL_W-1]}}, cur.vel_y};

    // signed x unsigned Q0.16; upper bits give a floor shift
    prod_x = $signed(cur.vel_x) * $signed({1'b0, cfg.decay});
    prod_y = $signed(cur.vel_y) * $signed({1'b0, cfg.decay});

    sum_r = {1'b0, cur.radius} + {1'b0, cfg.growth};

    if (sum_x[prtu_pkg::POS_W] != sum_x[prtu_pkg::POS_W-1]) begin
      upd.pos_x = sum_x[prtu_pkg::POS_W] ? {1'b1, {(prtu_pkg::POS_W-1){1'b0}}}
                                          : {1'b0, {(prtu_pkg::POS_W-1){1'b1}}};
    end else begin
      upd.pos_x = sum_x[prtu_pkg::POS_W-1:0];
    end

    if (sum_y[prtu_pkg::POS_W] != sum_y[prtu_pkg::POS_W-1]) begin
      upd.pos_y = sum_y[prtu_pkg::POS_W] ? {1'b1, {(prtu_pkg::POS_W-1){1'b0}}}
                                          : {1'b0, {(prtu_pkg::POS_W-1){1'b1}}};
    end else begin
      upd.pos_y = sum_y[prtu_pkg::POS_W-1:0];
    end

    upd.vel_x  = prod_x[prtu_pkg::CFG_W +: prtu_pkg::VEL_W];
    upd.vel_y  = prod_y[prtu_pkg::CFG_W +: prtu_pkg::VEL_W];
    upd.radius = sum_r[prtu_pkg::RAD_W] ? {prtu_pkg::RAD_W{1'b1}} : sum_r[prtu_pkg::RAD_W-1:0];
  end

endmodule

// File: design/particle_ring_update.sv
// Particle ring store: adds overwrite the oldest entry when full; ticks walk and update.
// An add is written into memory when accepted. A tick reads the oldest particle into a
// register, then gives one result per cycle while out_tready is high, reading, updating
// and writing back one particle per cycle through the single memory.
// Reset (synchronous, rst_n low) clears head, count, walker and output valid and restores
// the register defaults; the particle memory is not cleared. Depends on prtu_pkg, prtu_update.
module particle_ring_update #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [prtu_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [95:0]                in_tdata,   // pos_x, pos_y, vel_x, vel_y, radius
  input  logic [0:0]                 in_tuser,   // op
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,  // out_x, out_y, out_radius
  output logic [0:0]                 out_tuser,  // dense
  output logic                       out_tlast
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_WALK = 1'b1;

  prtu_pkg::entry_t mem [CAPACITY];

  logic [0:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] rank_r, rank_nxt;
  prtu_pkg::cfg_t   cfg_r;
  logic             out_valid_r;
  logic [63:0]      out_data_r;
  logic             out_dense_r, out_last_r;

  prtu_pkg::entry_t rd_data_r, upd, in_entry, wr_data;
  logic             rd_en, wr_en, in_acc, load, last_flag, dense_flag;
  logic [IDX_W-1:0] rd_addr, wr_addr, tail_slot, head_inc, slot_inc;
  logic [SUM_W-1:0] tail_sum;
  logic [CNT_W-1:0] rank_inc, quarter;

  prtu_update u_update (
    .cur (rd_data_r),
    .cfg (cfg_r),
    .upd (upd)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_entry  = in_tdata;
  assign load      = (state_r == ST_WALK) && (!out_valid_r || out_tready);

  assign rank_inc   = rank_r + CNT_W'(1);
  assign quarter    = count_r >> 2;
  assign last_flag  = (rank_inc == count_r);
  assign dense_flag = (rank_r < quarter);

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(CAPACITY)) begin
      tail_sum = tail_sum - SUM_W'(CAPACITY);
    end
    tail_slot = tail_sum[IDX_W-1:0];
    head_inc  = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);
    slot_inc  = (slot_r == IDX_W'(CAPACITY - 1)) ? '0 : slot_r + IDX_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    slot_nxt  = slot_r;
    rank_nxt  = rank_r;
    rd_en     = 1'b0;
    rd_addr   = slot_inc;
    wr_en     = 1'b0;
    wr_addr   = slot_r;
    wr_data   = upd;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser[0] == prtu_pkg::OP_ADD) begin
          wr_en   = 1'b1;
          wr_data = in_entry;
          if (count_r == CNT_W'(CAPACITY)) begin
            wr_addr  = head_r;
            head_nxt = head_inc;
          end else begin
            wr_addr   = tail_slot;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (in_acc && count_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          slot_nxt  = head_r;
          rank_nxt  = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (load) begin
          wr_en = 1'b1;
          if (last_flag) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en    = 1'b1;
            slot_nxt = slot_inc;
            rank_nxt = rank_inc;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      slot_r      <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_r.decay  <= prtu_pkg::DECAY_RESET;
      cfg_r.growth <= prtu_pkg::GROWTH_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      slot_r  <= slot_nxt;
      rank_r  <= rank_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr[0])
          prtu_pkg::REG_DECAY:  cfg_r.decay  <= cfg_wdata;
          prtu_pkg::REG_GROWTH: cfg_r.growth <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r  <= {rd_data_r.radius, rd_data_r.pos_y, rd_data_r.pos_x};
      out_dense_r <= dense_flag;
      out_last_r  <= last_flag;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_dense_r;
  assign out_tlast    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == prtu_pkg::OP_TICK && count_r == '0) |=> state_r == ST_IDLE)
    else $error("tick on empty store left idle");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_flag) |=> (state_r == ST_IDLE && out_tlast))
    else $error("walk did not end on last particle");

  a_count_stable_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> $stable(count_r) && $stable(head_r))
    else $error("ring pointers moved during walk");

endmodule

// File: bench/tb.sv
// Testbench for particle_ring_update: adds and ticks driven over stream ports, with results
// checked against a shadow copy of the particle ring kept in a small scoreboard class.
// Depends on prtu_pkg and the particle_ring_update RTL.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH       = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [prtu_pkg::POS_W-1:0] x;
    logic [prtu_pkg::POS_W-1:0] y;
    logic [prtu_pkg::RAD_W-1:0] r;
    logic                       dense;
    logic                       last;
  } frame_t;

  class particle_ring_shadow;
    logic signed [prtu_pkg::POS_W-1:0] px [DEPTH];
    logic signed [prtu_pkg::POS_W-1:0] py [DEPTH];
    logic signed [prtu_pkg::VEL_W-1:0] vx [DEPTH];
    logic signed [prtu_pkg::VEL_W-1:0] vy [DEPTH];
    logic        [prtu_pkg::RAD_W-1:0] rd [DEPTH];
    int                                head;
    int                                count;
    logic        [prtu_pkg::CFG_W-1:0] decay;
    logic        [prtu_pkg::CFG_W-1:0] growth;
    frame_t                            due_frames [$];
    int                                mismatches;

    function new();
      head       = 0;
      count      = 0;
      decay      = prtu_pkg::DECAY_RESET;
      growth     = prtu_pkg::GROWTH_RESET;
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("%0t MISMATCH %s", $realtime, msg);
    endtask

    function logic signed [prtu_pkg::POS_W-1:0] moved(
        logic signed [prtu_pkg::POS_W-1:0] p,
        logic signed [prtu_pkg::VEL_W-1:0] v);
      int s;
      s = p + v;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      return s[prtu_pkg::POS_W-1:0];
    endfunction

    // floor(v * decay / 2^16) via arithmetic shift
    function logic signed [prtu_pkg::VEL_W-1:0] slowed(
        logic signed [prtu_pkg::VEL_W-1:0] v);
      longint prod;
      prod = longint'(v) * longint'(decay);
      prod = prod >>> 16;
      return prod[prtu_pkg::VEL_W-1:0];
    endfunction

    function void accept_item(logic op, prtu_pkg::entry_t e);
      int     slot;
      int     quarter;
      int     r;
      frame_t f;
      if (op == prtu_pkg::OP_ADD) begin
        if (count < DEPTH) begin
          slot = (head + count) % DEPTH;
          count++;
        end else begin
          slot = head;
          head = (head + 1) % DEPTH;
        end
        px[slot] = e.pos_x;
        py[slot] = e.pos_y;
        vx[slot] = e.vel_x;
        vy[slot] = e.vel_y;
        rd[slot] = e.radius;
      end else begin
        quarter = count / 4;
        slot    = head;
        for (int i = 0; i < count; i++) begin
          f.x     = px[slot];
          f.y     = py[slot];
          f.r     = rd[slot];
          f.dense = (i < quarter);
          f.last  = (i + 1 == count);
          due_frames.push_back(f);
          px[slot] = moved(px[slot], vx[slot]);
          py[slot] = moved(py[slot], vy[slot]);
          vx[slot] = slowed(vx[slot]);
          vy[slot] = slowed(vy[slot]);
          r = rd[slot] + growth;
          rd[slot] = (r > 65535) ? 16'hFFFF : r[prtu_pkg::RAD_W-1:0];
          slot = (slot + 1) % DEPTH;
        end
      end
    endfunction

    task check_frame(frame_t got);
      frame_t want;
      if (due_frames.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      want = due_frames.pop_front();
      if (got.x !== want.x)
        report($sformatf("out_x got %h want %h", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("out_y got %h want %h", got.y, want.y));
      if (got.r !== want.r)
        report($sformatf("out_radius got %h want %h", got.r, want.r));
      if (got.dense !== want.dense)
        report($sformatf("dense got %b want %b", got.dense, want.dense));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask

    task flush_check();
      while (due_frames.size() != 0) begin
        void'(due_frames.pop_front());
        report("expected result never arrived");
      end
    endtask
  endclass

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       cfg_we     = 1'b0;
  logic [0:0]                 cfg_addr   = '0;
  logic [prtu_pkg::CFG_W-1:0] cfg_wdata  = '0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [95:0]                in_tdata   = '0;  // pos_x, pos_y, vel_x, vel_y, radius
  logic [0:0]                 in_tuser   = '0;  // op
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [63:0]                out_tdata;        // out_x, out_y, out_radius
  logic [0:0]                 out_tuser;        // dense
  logic                       out_tlast;

  particle_ring_shadow shadow = new();
  int                  idle_pct  = 0;
  int                  stall_pct = 0;
  int                  quiet     = 0;

  particle_ring_update #(.CAPACITY(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    frame_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.x     = out_tdata[23:0];
      got.y     = out_tdata[47:24];
      got.r     = out_tdata[63:48];
      got.dense = out_tuser[0];
      got.last  = out_tlast;
      shadow.check_frame(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("%0t no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [prtu_pkg::POS_W-1:0] pick_pos();
    case ($urandom_range(7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      default: return prtu_pkg::POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16(logic [15:0] hi, logic [15:0] lo);
    case ($urandom_range(7))
      0:       return hi;
      1:       return lo;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic prtu_pkg::entry_t random_entry();
    prtu_pkg::entry_t e;
    e.pos_x  = pick_pos();
    e.pos_y  = pick_pos();
    e.vel_x  = pick16(16'h7FFF, 16'h8000);
    e.vel_y  = pick16(16'h7FFF, 16'h8000);
    e.radius = pick16(16'hFFFF, 16'h0000);
    return e;
  endfunction

  function automatic prtu_pkg::entry_t make_entry(logic [23:0] x, logic [23:0] y,
                                                  logic [15:0] vx, logic [15:0] vy,
                                                  logic [15:0] r);
    prtu_pkg::entry_t e;
    e.pos_x  = x;
    e.pos_y  = y;
    e.vel_x  = vx;
    e.vel_y  = vy;
    e.radius = r;
    return e;
  endfunction

  task send_item(logic op, prtu_pkg::entry_t e);
    in_tuser  <= op;
    in_tdata  <= e;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    shadow.accept_item(op, e);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold the sender until every expected result is in, then let the block go quiet
  task settle();
    in_tvalid <= 1'b0;
    while (shadow.due_frames.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task write_regs(logic [prtu_pkg::CFG_W-1:0] decay, logic [prtu_pkg::CFG_W-1:0] growth);
    cfg_we    <= 1'b1;
    cfg_addr  <= prtu_pkg::REG_DECAY;
    cfg_wdata <= decay;
    @(posedge clk);
    shadow.decay = decay;
    cfg_addr  <= prtu_pkg::REG_GROWTH;
    cfg_wdata <= growth;
    @(posedge clk);
    shadow.growth = growth;
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, field extremes, saturation of position and radius
    send_item(prtu_pkg::OP_TICK, random_entry());
    send_item(prtu_pkg::OP_ADD,
              make_entry(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 16'hFFFF));
    send_item(prtu_pkg::OP_ADD,
              make_entry(24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 16'h0000));
    send_item(prtu_pkg::OP_ADD,
              make_entry(24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000));
    send_item(prtu_pkg::OP_ADD,
              make_entry(24'hFFFFFF, 24'h000001, 16'hFFFF, 16'h0001, 16'hFFF0));
    send_item(prtu_pkg::OP_TICK, random_entry());
    send_item(prtu_pkg::OP_TICK, random_entry());
    send_item(prtu_pkg::OP_TICK, random_entry());
    repeat (4) send_item(prtu_pkg::OP_ADD, random_entry());
    send_item(prtu_pkg::OP_TICK, random_entry());

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) settle();
      case (ph)
        1: begin
          write_regs(16'hFFFF, 16'hFFFF);
          idle_pct  = 72;
          stall_pct = 0;
        end
        2: begin
          write_regs(16'h0000, 16'h0000);
          idle_pct  = 0;
          stall_pct = 72;
        end
        3: begin
          write_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)));
          idle_pct  = 12;
          stall_pct = 12;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      repeat (85)
        send_item(($urandom_range(99) < 22) ? prtu_pkg::OP_TICK : prtu_pkg::OP_ADD,
                  random_entry());
    end

    settle();
    shadow.flush_check();
    if (shadow.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
